// ===== src/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// slcd_pkg
// types and codes shared by the start/length/checksum deframer
// ----------------------------------------------------------------------------
`default_nettype none

package slcd_pkg;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN     = 3'd1,
        PH_DATA    = 3'd2,
        PH_SUM     = 3'd3,
        PH_PLAY_RD = 3'd4,
        PH_PLAY_WR = 3'd5
    } phase_t;

    // event codes
    localparam logic [2:0] EV_PROGRESS = 3'd0;
    localparam logic [2:0] EV_RESYNC   = 3'd1;
    localparam logic [2:0] EV_LEN_ERR  = 3'd2;
    localparam logic [2:0] EV_SUM_ERR  = 3'd3;
    localparam logic [2:0] EV_FRAME_OK = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int TDATA_W     = 152;
    localparam int TUSER_W     = 4;

    // counter selected for the shared incrementer
    typedef enum logic [2:0] {
        CNT_NONE    = 3'd0,
        CNT_RESYNC  = 3'd1,
        CNT_LEN_ERR = 3'd2,
        CNT_SUM_ERR = 3'd3,
        CNT_GOOD    = 3'd4
    } cnt_sel_t;

    typedef struct packed {
        logic [31:0] good_frame_count;
        logic [31:0] checksum_error_count;
        logic [31:0] length_error_count;
        logic [31:0] resync_count;
        logic [5:0]  frame_length;
        logic [4:0]  data_index;
        logic [7:0]  data_byte;
        logic        last;
        logic        data_valid;
        logic [2:0]  event_res;
    } result_t;

endpackage

`default_nettype wire

// ===== src/sof_length_checksum_deframer.sv =====
// ----------------------------------------------------------------------------
// sof_length_checksum_deframer
// hunts for a start byte, checks length and additive checksum, replays good
// payloads from a byte store as a run of results
// an event result is registered and valid in the cycle after its byte transfer
// throughput: one byte per cycle outside playback, while the output register is free
// a good frame replays byte by byte (store read, then output load), with
// input not ready during the playback
// reset: phase and counters cleared, start byte 0, max length 32,
// payload store not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module sof_length_checksum_deframer #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: rx_byte[7:0]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,
    // m_tdata: data_byte[7:0], data_index[12:8], frame_length[18:13],
    // resync_count[50:19], length_error_count[82:51],
    // checksum_error_count[114:83], good_frame_count[146:115], zero pad
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [slcd_pkg::TDATA_W-1:0]          m_tdata,
    // m_tuser: event_res[2:0], data_valid[3]
    output logic [slcd_pkg::TUSER_W-1:0]          m_tuser,
    output logic                                  m_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [slcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [slcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0] start_byte_reg;
    logic [5:0] max_length_reg;

    slcd_pkg::result_t out_reg;
    logic              out_valid_reg;
    slcd_pkg::result_t res;
    logic              res_load;
    logic              out_free;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'd0;
            max_length_reg <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slcd_pkg::REG_START_BYTE: start_byte_reg <= cfg_data;
                slcd_pkg::REG_MAX_LENGTH: max_length_reg <= cfg_data[5:0];
                default:                  start_byte_reg <= start_byte_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    slcd_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_ready   (s_tready),
        .out_free   (out_free),
        .start_byte (start_byte_reg),
        .max_length (max_length_reg),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_load   (res_load),
        .res        (res)
    );

    slcd_store #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register, refilled in the cycle its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = {out_reg.data_valid, out_reg.event_res};
    assign m_tdata  = {5'd0,
                       out_reg.good_frame_count,
                       out_reg.checksum_error_count,
                       out_reg.length_error_count,
                       out_reg.resync_count,
                       out_reg.frame_length,
                       out_reg.data_index,
                       out_reg.data_byte};

endmodule

`default_nettype wire

// ===== src/slcd_store.sv =====
// ----------------------------------------------------------------------------
// slcd_store
// payload byte memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_store #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/slcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// slcd_ctrl
// deframing sequencer with shared checksum adder and shared counter incrementer
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_ctrl #(
    parameter int MAX_PAYLOAD = 32,
    parameter int LEN_W       = 6,
    parameter int ADDR_W      = 5
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [7:0]           in_byte,
    output logic                      in_ready,
    input  wire logic                 out_free,
    input  wire logic [7:0]           start_byte,
    input  wire logic [5:0]           max_length,
    output logic                      wr_en,
    output logic      [ADDR_W-1:0]    wr_addr,
    output logic                      rd_en,
    output logic      [ADDR_W-1:0]    rd_addr,
    input  wire logic [7:0]           rd_data,
    output logic                      res_load,
    output slcd_pkg::result_t         res
);

    slcd_pkg::phase_t   state_reg, state_next;
    slcd_pkg::cnt_sel_t cnt_sel;

    logic [LEN_W-1:0] stored_reg, stored_next;
    logic [LEN_W-1:0] exp_reg, exp_next;
    logic [7:0]       sum_reg, sum_next;
    logic [31:0]      resync_reg, resync_next;
    logic [31:0]      len_err_reg, len_err_next;
    logic [31:0]      sum_err_reg, sum_err_next;
    logic [31:0]      good_reg, good_next;

    logic             in_fire;
    logic [7:0]       lim;
    logic             len_ok;
    logic [7:0]       add_a, add_sum;
    logic [31:0]      inc_in, inc_out;
    logic [LEN_W-1:0] idx_inc;
    logic [7:0]       stored8, exp8;
    logic             play_last;

    assign in_ready = ((state_reg == slcd_pkg::PH_HUNT) || (state_reg == slcd_pkg::PH_LEN)
                       || (state_reg == slcd_pkg::PH_DATA) || (state_reg == slcd_pkg::PH_SUM))
                      && out_free;
    assign in_fire  = in_valid && in_ready;

    // effective length limit
    assign lim    = ({2'b00, max_length} > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD)
                                                           : {2'b00, max_length};
    assign len_ok = (in_byte != 8'd0) && (in_byte <= lim);

    // shared checksum adder: seeds from zero on the length byte
    assign add_a   = (state_reg == slcd_pkg::PH_LEN) ? 8'd0 : sum_reg;
    assign add_sum = add_a + in_byte;

    // shared counter incrementer
    always_comb
    begin
        case (cnt_sel)
            slcd_pkg::CNT_RESYNC:  inc_in = resync_reg;
            slcd_pkg::CNT_LEN_ERR: inc_in = len_err_reg;
            slcd_pkg::CNT_SUM_ERR: inc_in = sum_err_reg;
            slcd_pkg::CNT_GOOD:    inc_in = good_reg;
            default:               inc_in = 32'd0;
        endcase
    end
    assign inc_out = inc_in + 32'd1;

    assign idx_inc   = stored_reg + LEN_W'(1);
    assign stored8   = 8'(stored_reg);
    assign exp8      = 8'(exp_reg);
    assign play_last = (idx_inc == exp_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slcd_pkg::PH_HUNT:
            begin
                if (in_fire && (in_byte == start_byte))
                    state_next = slcd_pkg::PH_LEN;
            end
            slcd_pkg::PH_LEN:
            begin
                if (in_fire)
                    state_next = len_ok ? slcd_pkg::PH_DATA : slcd_pkg::PH_HUNT;
            end
            slcd_pkg::PH_DATA:
            begin
                if (in_fire && (idx_inc >= exp_reg))
                    state_next = slcd_pkg::PH_SUM;
            end
            slcd_pkg::PH_SUM:
            begin
                if (in_fire)
                    state_next = (in_byte == sum_reg) ? slcd_pkg::PH_PLAY_RD
                                                      : slcd_pkg::PH_HUNT;
            end
            slcd_pkg::PH_PLAY_RD:
            begin
                state_next = slcd_pkg::PH_PLAY_WR;
            end
            slcd_pkg::PH_PLAY_WR:
            begin
                if (out_free)
                    state_next = play_last ? slcd_pkg::PH_HUNT : slcd_pkg::PH_PLAY_RD;
            end
            default:
            begin
                state_next = slcd_pkg::PH_HUNT;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        stored_next = stored_reg;
        exp_next    = exp_reg;
        sum_next    = sum_reg;
        cnt_sel     = slcd_pkg::CNT_NONE;
        wr_en       = 1'b0;
        wr_addr     = stored_reg[ADDR_W-1:0];
        rd_en       = 1'b0;
        rd_addr     = stored_reg[ADDR_W-1:0];
        res_load    = 1'b0;
        res.event_res  = slcd_pkg::EV_PROGRESS;
        res.data_valid = 1'b0;
        res.data_byte  = 8'd0;
        res.data_index = 5'd0;
        res.frame_length = 6'd0;
        res.last       = 1'b1;

        case (state_reg)
            slcd_pkg::PH_HUNT:
            begin
                if (in_fire)
                begin
                    res_load = 1'b1;
                    if (in_byte != start_byte)
                    begin
                        cnt_sel       = slcd_pkg::CNT_RESYNC;
                        res.event_res = slcd_pkg::EV_RESYNC;
                    end
                end
            end
            slcd_pkg::PH_LEN:
            begin
                if (in_fire)
                begin
                    res_load = 1'b1;
                    if (len_ok)
                    begin
                        exp_next    = in_byte[LEN_W-1:0];
                        stored_next = '0;
                        sum_next    = add_sum;
                    end
                    else
                    begin
                        cnt_sel       = slcd_pkg::CNT_LEN_ERR;
                        res.event_res = slcd_pkg::EV_LEN_ERR;
                    end
                end
            end
            slcd_pkg::PH_DATA:
            begin
                if (in_fire)
                begin
                    res_load    = 1'b1;
                    wr_en       = 1'b1;
                    stored_next = idx_inc;
                    sum_next    = add_sum;
                end
            end
            slcd_pkg::PH_SUM:
            begin
                if (in_fire)
                begin
                    if (in_byte == sum_reg)
                    begin
                        // good frame: results come from the playback run
                        cnt_sel     = slcd_pkg::CNT_GOOD;
                        stored_next = '0;
                    end
                    else
                    begin
                        res_load      = 1'b1;
                        cnt_sel       = slcd_pkg::CNT_SUM_ERR;
                        res.event_res = slcd_pkg::EV_SUM_ERR;
                    end
                end
            end
            slcd_pkg::PH_PLAY_RD:
            begin
                rd_en = 1'b1;
            end
            slcd_pkg::PH_PLAY_WR:
            begin
                if (out_free)
                begin
                    res_load         = 1'b1;
                    res.event_res    = slcd_pkg::EV_FRAME_OK;
                    res.data_valid   = 1'b1;
                    res.data_byte    = rd_data;
                    res.data_index   = stored8[4:0];
                    res.frame_length = exp8[5:0];
                    res.last         = play_last;
                    stored_next      = idx_inc;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase

        resync_next  = (cnt_sel == slcd_pkg::CNT_RESYNC)  ? inc_out : resync_reg;
        len_err_next = (cnt_sel == slcd_pkg::CNT_LEN_ERR) ? inc_out : len_err_reg;
        sum_err_next = (cnt_sel == slcd_pkg::CNT_SUM_ERR) ? inc_out : sum_err_reg;
        good_next    = (cnt_sel == slcd_pkg::CNT_GOOD)    ? inc_out : good_reg;

        // a result shows the counters as they stand after its byte
        res.resync_count         = resync_next;
        res.length_error_count   = len_err_next;
        res.checksum_error_count = sum_err_next;
        res.good_frame_count     = good_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= slcd_pkg::PH_HUNT;
            stored_reg  <= '0;
            exp_reg     <= '0;
            sum_reg     <= 8'd0;
            resync_reg  <= 32'd0;
            len_err_reg <= 32'd0;
            sum_err_reg <= 32'd0;
            good_reg    <= 32'd0;
        end
        else
        begin
            state_reg   <= state_next;
            stored_reg  <= stored_next;
            exp_reg     <= exp_next;
            sum_reg     <= sum_next;
            resync_reg  <= resync_next;
            len_err_reg <= len_err_next;
            sum_err_reg <= sum_err_next;
            good_reg    <= good_next;
        end
    end

endmodule

`default_nettype wire
